// ----- rtl/emp_pkg.sv -----
// shared types and constants of the energy meter poll master
// item structs, result kinds, error codes, register indexes, frame layout
// no dependencies
package emp_pkg;

  localparam int FRAME_BYTES = 7;
  localparam int MS_W        = 16;

  // result kinds
  localparam logic [2:0] KIND_TX       = 3'd0;
  localparam logic [2:0] KIND_VOLTAGE  = 3'd1;
  localparam logic [2:0] KIND_CURRENT  = 3'd2;
  localparam logic [2:0] KIND_ERROR    = 3'd3;
  localparam logic [2:0] KIND_COMPLETE = 3'd4;

  // error codes
  localparam logic [1:0] ERR_CHECKSUM = 2'd0;
  localparam logic [1:0] ERR_RESPONSE = 2'd1;
  localparam logic [1:0] ERR_TIMEOUT  = 2'd2;

  // operations
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_BYTE = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_DEVICE_ADDRESS  = 2'd0;
  localparam logic [1:0] REG_READ_TIMEOUT_MS = 2'd1;
  localparam logic [1:0] REG_SETTLE_MS       = 2'd2;

  localparam logic [31:0]   DEVICE_ADDRESS_RST  = 32'hC0A8_0101;
  localparam logic [MS_W-1:0] READ_TIMEOUT_RST  = 16'd3000;
  localparam logic [MS_W-1:0] SETTLE_RST        = 16'd1000;

  // frame bytes
  localparam logic [7:0] CMD_VOLT = 8'hB0;
  localparam logic [7:0] RSP_VOLT = 8'hA0;
  localparam logic [7:0] CMD_CURR = 8'hB1;
  localparam logic [7:0] RSP_CURR = 8'hA1;

  localparam logic [2:0] LAST_BYTE = 3'(FRAME_BYTES - 1);

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [19:0] voltage_tenths;
    logic [22:0] current_hundredths;
    logic [1:0]  error_code;
    logic [31:0] error_total;
  } out_item_t;

  typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

  // results caused by one item, handed from the sequencer to the emitter
  typedef struct packed {
    logic      load;
    logic      is_frame;
    frame_t    frame;
    out_item_t tmpl;
  } batch_t;

endpackage

// ----- rtl/emp_core.sv -----
// polling sequencer: phase, timers, reply capture, checks and readings
// updates all polling state in the cycle an item is accepted, builds the result batch
// depends on emp_pkg
module emp_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              accept,
  input  emp_pkg::in_item_t item,
  output emp_pkg::batch_t   batch
);
  import emp_pkg::*;

  typedef enum logic [2:0] {
    PH_SEND_V = 3'd0,
    PH_RECV_V = 3'd1,
    PH_SEND_C = 3'd2,
    PH_RECV_C = 3'd3,
    PH_SETTLE = 3'd4
  } phase_t;

  logic [31:0]     device_address;
  logic [MS_W-1:0] read_timeout_ms;
  logic [MS_W-1:0] settle_ms;

  phase_t          phase, phase_next;
  logic [MS_W-1:0] elapsed, elapsed_next;
  logic [2:0]      reply_count, reply_count_next;
  logic [31:0]     error_counter, error_counter_next;
  logic [19:0]     held_voltage, held_voltage_next;
  logic [7:0]      reply_bytes [FRAME_BYTES-1];

  logic        store_byte;
  logic [7:0]  sum;
  logic [7:0]  cmd;
  logic [7:0]  rsp;
  logic [15:0] value;
  logic [31:0] err_inc;
  logic [1:0]  code;
  logic [2:0]  kind;
  logic [22:0] current;

  assign value   = {reply_bytes[1], reply_bytes[2]};
  assign sum     = reply_bytes[0] + reply_bytes[1] + reply_bytes[2]
                 + reply_bytes[3] + reply_bytes[4] + reply_bytes[5];
  assign err_inc = (error_counter == '1) ? error_counter : error_counter + 32'd1;
  assign rsp     = (phase == PH_RECV_V) ? RSP_VOLT : RSP_CURR;
  assign cmd     = (phase == PH_SEND_V) ? CMD_VOLT : CMD_CURR;

  always_comb begin
    phase_next         = phase;
    elapsed_next       = elapsed;
    reply_count_next   = reply_count;
    error_counter_next = error_counter;
    held_voltage_next  = held_voltage;
    store_byte         = 1'b0;
    kind               = KIND_TX;
    code               = ERR_CHECKSUM;
    current            = '0;
    batch.load         = 1'b0;
    batch.is_frame     = 1'b0;

    if (item.operation == OP_TICK) begin
      case (phase)
        PH_SEND_V, PH_SEND_C: begin
          phase_next       = (phase == PH_SEND_V) ? PH_RECV_V : PH_RECV_C;
          reply_count_next = '0;
          elapsed_next     = '0;
          batch.load       = 1'b1;
          batch.is_frame   = 1'b1;
        end
        PH_SETTLE: begin
          if (elapsed >= settle_ms) begin
            phase_next   = PH_SEND_V;
            elapsed_next = '0;
            kind         = KIND_COMPLETE;
            batch.load   = 1'b1;
          end else if (elapsed >= read_timeout_ms) begin
            kind       = KIND_ERROR;
            code       = ERR_TIMEOUT;
            batch.load = 1'b1;
          end else begin
            elapsed_next = elapsed + 1'b1;
          end
        end
        default: begin
          if (elapsed >= read_timeout_ms) begin
            kind       = KIND_ERROR;
            code       = ERR_TIMEOUT;
            batch.load = 1'b1;
          end else begin
            elapsed_next = elapsed + 1'b1;
          end
        end
      endcase
    end else if ((phase == PH_RECV_V || phase == PH_RECV_C)
                 && !(item.rx_byte == 8'd0 && reply_count == 3'd0)) begin
      elapsed_next = '0;
      if (reply_count != LAST_BYTE) begin
        store_byte       = 1'b1;
        reply_count_next = reply_count + 3'd1;
      end else begin
        reply_count_next = '0;
        batch.load       = 1'b1;
        if (sum != item.rx_byte) begin
          kind = KIND_ERROR;
          code = ERR_CHECKSUM;
        end else if (reply_bytes[0] != rsp) begin
          kind = KIND_ERROR;
          code = ERR_RESPONSE;
        end else if (phase == PH_RECV_V) begin
          kind              = KIND_VOLTAGE;
          held_voltage_next = {4'd0, value} * 20'd10 + {12'd0, reply_bytes[3]};
          phase_next        = PH_SEND_C;
        end else begin
          kind       = KIND_CURRENT;
          current    = {7'd0, value} * 23'd100 + {15'd0, reply_bytes[3]};
          phase_next = PH_SETTLE;
        end
      end
    end

    // every error restarts the cycle
    if (batch.load && kind == KIND_ERROR) begin
      error_counter_next = err_inc;
      phase_next         = PH_SEND_V;
      elapsed_next       = '0;
      reply_count_next   = '0;
    end

    batch.frame[0] = cmd;
    batch.frame[1] = device_address[31:24];
    batch.frame[2] = device_address[23:16];
    batch.frame[3] = device_address[15:8];
    batch.frame[4] = device_address[7:0];
    batch.frame[5] = 8'd0;
    batch.frame[6] = cmd + device_address[31:24] + device_address[23:16]
                   + device_address[15:8] + device_address[7:0];

    batch.tmpl.kind               = kind;
    batch.tmpl.tx_byte            = 8'd0;
    batch.tmpl.last               = 1'b0;
    batch.tmpl.voltage_tenths     = held_voltage_next;
    batch.tmpl.current_hundredths = current;
    batch.tmpl.error_code         = code;
    batch.tmpl.error_total        = error_counter_next;
    batch.load                    = batch.load && accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address  <= DEVICE_ADDRESS_RST;
      read_timeout_ms <= READ_TIMEOUT_RST;
      settle_ms       <= SETTLE_RST;
      phase           <= PH_SEND_V;
      elapsed         <= '0;
      reply_count     <= '0;
      error_counter   <= '0;
      held_voltage    <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DEVICE_ADDRESS:  device_address  <= cfg_data;
          REG_READ_TIMEOUT_MS: read_timeout_ms <= cfg_data[MS_W-1:0];
          REG_SETTLE_MS:       settle_ms       <= cfg_data[MS_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        phase         <= phase_next;
        elapsed       <= elapsed_next;
        reply_count   <= reply_count_next;
        error_counter <= error_counter_next;
        held_voltage  <= held_voltage_next;
      end
    end
  end

  // reply bytes need no reset, each is written before it is checked
  always_ff @(posedge clk) begin
    if (accept && store_byte) begin
      reply_bytes[reply_count] <= item.rx_byte;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    reply_count <= LAST_BYTE)
    else $error("reply count past frame end");

  a_send_to_recv: assert property (@(posedge clk) disable iff (rst)
    accept && item.operation == OP_TICK && phase == PH_SEND_V |=> phase == PH_RECV_V)
    else $error("voltage request not followed by receive");

  a_err_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> error_counter >= $past(error_counter))
    else $error("error count went down");

endmodule

// ----- rtl/emp_emit.sv -----
// result emitter: holds one batch and sends its results one per cycle while res_ready is high
// a request frame gives seven results, anything else one
// depends on emp_pkg
module emp_emit (
  input  logic               clk,
  input  logic               rst,
  input  emp_pkg::batch_t    batch,
  output logic               can_load,
  output logic               res_valid,
  input  logic               res_ready,
  output emp_pkg::out_item_t res
);
  import emp_pkg::*;

  logic      valid;
  logic      is_frame;
  logic [2:0] idx;
  frame_t    frame;
  out_item_t tmpl;
  logic      at_last;

  assign at_last  = !is_frame || idx == LAST_BYTE;
  assign can_load = !valid || (res_ready && at_last);
  assign res_valid = valid;

  always_comb begin
    res         = tmpl;
    res.tx_byte = is_frame ? frame[idx] : 8'd0;
    res.last    = at_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      idx   <= '0;
    end else if (batch.load) begin
      valid <= 1'b1;
      idx   <= '0;
    end else if (valid && res_ready) begin
      if (at_last) begin
        valid <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (batch.load) begin
      is_frame <= batch.is_frame;
      frame    <= batch.frame;
      tmpl     <= batch.tmpl;
    end
  end

  a_load_ok: assert property (@(posedge clk) disable iff (rst)
    batch.load |-> can_load)
    else $error("batch loaded over pending results");

  a_single_idx: assert property (@(posedge clk) disable iff (rst)
    valid && !is_frame |-> idx == 3'd0)
    else $error("single result with nonzero index");

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= LAST_BYTE)
    else $error("frame index out of range");

endmodule

// ----- rtl/energy_meter_poll_master.sv -----
// top level of the energy meter poll master
// instantiates the polling sequencer (emp_core) and the result emitter (emp_emit)
// depends on emp_pkg
//
// usage:
//   ev channel (ev_valid/ev_ready/ev) carries one item per event: a 1 ms tick
//   (operation 0) or a received serial byte (operation 1)
//   res channel (res_valid/res_ready/res) carries the results; res.last marks
//   the final result of an item, items that cause nothing give no result
//   cfg_we/cfg_index/cfg_data write device_address (0), read_timeout_ms (1)
//   and settle_ms (2); other indexes are ignored
// timing:
//   state is updated in the cycle an item is accepted; its first result shows
//   in the next cycle from the output register
//   a tick in a send phase gives a seven-byte request, one byte per cycle while
//   res_ready is high; every other item gives at most one result
//   ev_ready is high while the emitter is empty or handing over its last
//   result, so items that give at most one result flow back to back as long as res_ready stays high
// reset: phase back to the voltage request, timers, counts, error total and
//   held voltage cleared, registers to their defaults
// stall: a low res_ready holds the current result and blocks new items while one is pending
module energy_meter_poll_master (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               ev_valid,
  output logic               ev_ready,
  input  emp_pkg::in_item_t  ev,
  output logic               res_valid,
  input  logic               res_ready,
  output emp_pkg::out_item_t res
);
  import emp_pkg::*;

  batch_t batch;
  logic   accept;

  // an item is taken only when the emitter can absorb whatever it causes
  assign accept = ev_valid && ev_ready;

  emp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .item      (ev),
    .batch     (batch)
  );

  emp_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .batch     (batch),
    .can_load  (ev_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

// ----- dv/tb_energy_meter_poll_master.sv -----
// self-checking testbench of the energy meter poll master: ticks and reply bytes in,
// request bytes, readings, errors and cycle-complete results out, checked in order
// depends on emp_pkg and energy_meter_poll_master
module tb_energy_meter_poll_master;
  timeunit 1ns;
  timeprecision 1ps;
  import emp_pkg::*;

  localparam int CLK_HALF       = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int PHASE_ITEMS    = 15;
  localparam int MAX_REPORTS    = 40;
  localparam int SETTINGS_RUNS  = 6;
  // index outside the register map, the block must ignore it
  localparam logic [1:0] REG_UNUSED = 2'd3;

  // polling loop of the block
  typedef enum logic [2:0] {
    SEND_VOLT, RECV_VOLT, SEND_CURR, RECV_CURR, SETTLE
  } meter_phase_e;

  // registers plus internal state, one copy follows the block, one plans the stimulus
  typedef struct packed {
    logic [31:0]  address;
    logic [15:0]  timeout_ms;
    logic [15:0]  settle_ms;
    meter_phase_e phase;
    logic [15:0]  elapsed;
    frame_t       reply;
    logic [2:0]   count;
    logic [31:0]  errors;
    logic [19:0]  volts;
  } meter_state_t;

  typedef out_item_t [FRAME_BYTES-1:0] result_batch_t;

  logic      clk = 1'b0;
  logic      rst;
  logic      cfg_we;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;
  logic      ev_valid;
  logic      ev_ready;
  in_item_t  ev;
  logic      res_valid;
  logic      res_ready;
  out_item_t res;

  in_item_t     meter_events_q[$];   // items waiting for the driver
  out_item_t    meter_results_q[$];  // results the block still owes
  meter_state_t live_meter;          // follows accepted items
  meter_state_t plan_meter;          // runs ahead while the stimulus is built
  int           items_made;
  int           fail_count;
  int           idle_cycles;
  int           send_gap;
  int           recv_gap;
  bit           send_calm;
  bit           recv_calm;
  bit           ev_taken;
  bit           res_taken;
  bit           busy;
  int           fresh_n;
  result_batch_t fresh;
  out_item_t    want;

  energy_meter_poll_master i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ev_valid  (ev_valid),
    .ev_ready  (ev_ready),
    .ev        (ev),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor of the polling loop
  // ---------------------------------------------------------------------------

  function automatic meter_state_t reset_state();
    meter_state_t s;
    s            = '0;
    s.address    = DEVICE_ADDRESS_RST;
    s.timeout_ms = READ_TIMEOUT_RST;
    s.settle_ms  = SETTLE_RST;
    s.phase      = SEND_VOLT;
    return s;
  endfunction

  function automatic meter_state_t with_reg(meter_state_t s, logic [1:0] idx,
                                            logic [31:0] data);
    case (idx)
      REG_DEVICE_ADDRESS:  s.address    = data;
      REG_READ_TIMEOUT_MS: s.timeout_ms = data[15:0];
      REG_SETTLE_MS:       s.settle_ms  = data[15:0];
      default: ;
    endcase
    return s;
  endfunction

  function automatic bit receiving(meter_phase_e p);
    return p == RECV_VOLT || p == RECV_CURR;
  endfunction

  // every result carries the held voltage and the error total after its update
  function automatic out_item_t make_result(meter_state_t s, logic [2:0] kind,
                                            logic [7:0] tx, logic [22:0] amps,
                                            logic [1:0] code);
    out_item_t r;
    r.kind               = kind;
    r.tx_byte            = tx;
    r.last               = 1'b0;
    r.voltage_tenths     = s.volts;
    r.current_hundredths = amps;
    r.error_code         = code;
    r.error_total        = s.errors;
    return r;
  endfunction

  // any error restarts the loop at the voltage request
  task automatic meter_fault(inout meter_state_t s, input logic [1:0] code,
                             output out_item_t r);
    if (s.errors != '1) begin
      s.errors++;
    end
    s.phase   = SEND_VOLT;
    s.elapsed = '0;
    s.count   = '0;
    r = make_result(s, KIND_ERROR, '0, '0, code);
  endtask

  task automatic meter_step(inout meter_state_t s, input in_item_t it,
                            output int n, output result_batch_t out);
    frame_t      req;
    logic [7:0]  sum;
    logic [22:0] amps;
    int          i;
    n   = 0;
    out = '0;
    if (it.operation == OP_TICK) begin
      case (s.phase)
        SEND_VOLT, SEND_CURR: begin
          // command, address msb first, zero data byte, additive checksum
          req[0] = (s.phase == SEND_VOLT) ? CMD_VOLT : CMD_CURR;
          req[1] = s.address[31:24];
          req[2] = s.address[23:16];
          req[3] = s.address[15:8];
          req[4] = s.address[7:0];
          req[5] = 8'h00;
          sum    = '0;
          for (i = 0; i < FRAME_BYTES - 1; i++) begin
            sum += req[i];
          end
          req[FRAME_BYTES-1] = sum;
          for (i = 0; i < FRAME_BYTES; i++) begin
            out[i] = make_result(s, KIND_TX, req[i], '0, '0);
          end
          n         = FRAME_BYTES;
          s.phase   = (s.phase == SEND_VOLT) ? RECV_VOLT : RECV_CURR;
          s.count   = '0;
          s.elapsed = '0;
        end
        SETTLE: begin
          // settle end wins over the read timeout on the same tick
          if (s.elapsed >= s.settle_ms) begin
            s.phase   = SEND_VOLT;
            s.elapsed = '0;
            out[0]    = make_result(s, KIND_COMPLETE, '0, '0, '0);
            n         = 1;
          end else if (s.elapsed >= s.timeout_ms) begin
            meter_fault(s, ERR_TIMEOUT, out[0]);
            n = 1;
          end else begin
            s.elapsed++;
          end
        end
        default: begin
          if (s.elapsed >= s.timeout_ms) begin
            meter_fault(s, ERR_TIMEOUT, out[0]);
            n = 1;
          end else begin
            s.elapsed++;
          end
        end
      endcase
    end else if (receiving(s.phase) && !(it.rx_byte == 8'h00 && s.count == 0)) begin
      s.reply[s.count] = it.rx_byte;
      s.count++;
      s.elapsed = '0;
      if (s.count == FRAME_BYTES) begin
        s.count = '0;
        sum     = '0;
        for (i = 0; i < FRAME_BYTES - 1; i++) begin
          sum += s.reply[i];
        end
        if (sum != s.reply[FRAME_BYTES-1]) begin
          meter_fault(s, ERR_CHECKSUM, out[0]);
        end else if (s.reply[0] != ((s.phase == RECV_VOLT) ? RSP_VOLT : RSP_CURR)) begin
          meter_fault(s, ERR_RESPONSE, out[0]);
        end else if (s.phase == RECV_VOLT) begin
          s.volts = 20'({s.reply[1], s.reply[2]}) * 20'd10 + 20'(s.reply[3]);
          s.phase = SEND_CURR;
          out[0]  = make_result(s, KIND_VOLTAGE, '0, '0, '0);
        end else begin
          amps    = 23'({s.reply[1], s.reply[2]}) * 23'd100 + 23'(s.reply[3]);
          s.phase = SETTLE;
          out[0]  = make_result(s, KIND_CURRENT, '0, amps, '0);
        end
        n = 1;
      end
    end
    if (n > 0) begin
      out[n-1].last = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------

  // mostly short gaps, now and then a long one, none during calm stretches
  function automatic int idle_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_data();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // nonzero so the byte is not skipped as a leading zero
  function automatic logic [7:0] wrong_code(logic [7:0] good);
    logic [7:0] c;
    if ($urandom_range(0, 1) == 1) begin
      return (good == RSP_VOLT) ? RSP_CURR : RSP_VOLT;
    end
    c = 8'($urandom_range(1, 255));
    if (c == good) begin
      c = c ^ 8'h01;
    end
    return c;
  endfunction

  // queue one item and run it through the planning copy
  task automatic push_item(input logic op, input logic [7:0] b);
    in_item_t      it;
    int            n;
    result_batch_t scratch;
    it.operation = op;
    it.rx_byte   = b;
    // bytes outside the receive phases are dropped and do not count
    if (op == OP_TICK || receiving(plan_meter.phase)) begin
      items_made++;
    end
    meter_events_q.push_back(it);
    meter_step(plan_meter, it, n, scratch);
  endtask

  // seven-byte reply; sum_off nonzero breaks the checksum, jitter slips in ticks
  task automatic push_frame(input logic [7:0] code, input logic [7:0] d1,
                            input logic [7:0] d2, input logic [7:0] d3,
                            input logic [7:0] sum_off, input bit jitter);
    frame_t     f;
    logic [7:0] sum;
    int         i;
    f[0] = code;
    f[1] = d1;
    f[2] = d2;
    f[3] = d3;
    f[4] = 8'($urandom);
    f[5] = 8'($urandom);
    sum  = '0;
    for (i = 0; i < FRAME_BYTES - 1; i++) begin
      sum += f[i];
    end
    f[FRAME_BYTES-1] = sum + sum_off;
    for (i = 0; i < FRAME_BYTES; i++) begin
      // a tick between bytes only while it cannot time out
      if (jitter && plan_meter.elapsed < plan_meter.timeout_ms &&
          $urandom_range(0, 2) == 0) begin
        push_item(OP_TICK, 8'($urandom));
      end
      push_item(OP_BYTE, f[i]);
    end
  endtask

  // random part: well-formed polling cycles with random content, some broken, some noise
  task automatic run_random(input int target);
    int         start;
    int         r;
    logic [7:0] code;
    logic [7:0] sum_off;
    start = items_made;
    while (items_made - start < target) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        push_item(1'($urandom_range(0, 1)), 8'($urandom));
      end else if (!receiving(plan_meter.phase)) begin
        // stray byte now and then, otherwise the tick that moves the loop on
        if (r < 16) begin
          push_item(OP_BYTE, 8'($urandom));
        end else begin
          push_item(OP_TICK, 8'($urandom));
        end
      end else if (r < 14 && plan_meter.timeout_ms <= 20) begin
        // meter stays silent until the read timeout
        while (receiving(plan_meter.phase)) begin
          push_item(OP_TICK, 8'($urandom));
        end
      end else begin
        code    = (plan_meter.phase == RECV_VOLT) ? RSP_VOLT : RSP_CURR;
        sum_off = 8'h00;
        if (r < 30) begin
          repeat ($urandom_range(1, 2)) push_item(OP_BYTE, 8'h00);
        end
        if (r >= 30 && r < 40) begin
          sum_off = 8'($urandom_range(1, 255));
        end else if (r >= 40 && r < 50) begin
          code = wrong_code(code);
        end
        push_frame(code, pick_data(), pick_data(), pick_data(), sum_off, (r % 3) == 0);
      end
    end
  endtask

  // register writes only while the block is idle
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we     <= 1'b1;
    cfg_index  <= idx;
    cfg_data   <= data;
    live_meter = with_reg(live_meter, idx, data);
    plan_meter = with_reg(plan_meter, idx, data);
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // all items accepted, all results seen, then the block's own latency
  task automatic wait_quiet();
    while (meter_events_q.size() != 0 || ev_valid || meter_results_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, exp_v, act_v);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: one item at a time from the pending queue, changes at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      ev_valid <= 1'b0;
    end else if (!ev_valid || ev_taken) begin
      // an offered item is held until the rising edge takes it
      ev_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        ev_valid <= 1'b0;
      end else if (meter_events_q.size() != 0) begin
        ev       <= meter_events_q.pop_front();
        ev_valid <= 1'b1;
        if ($urandom_range(0, 39) == 0) begin
          send_calm = !send_calm;
        end
        send_gap = idle_gap(send_calm);
      end else begin
        ev_valid <= 1'b0;
      end
    end
  end

  // result side may stall after a taken result
  always @(negedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_taken) begin
        res_taken = 1'b0;
        if ($urandom_range(0, 39) == 0) begin
          recv_calm = !recv_calm;
        end
        recv_gap = idle_gap(recv_calm);
      end
      if (recv_gap > 0) begin
        recv_gap--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks taken results, predicts taken items, watches for a hang
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      busy = 1'b0;
      // check before predicting so a result never meets its own item's expectation
      if (res_valid && res_ready) begin
        busy      = 1'b1;
        res_taken = 1'b1;
        if (meter_results_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("%0t: result expected none actual kind 0x%0h", $time, res.kind);
          end
        end else begin
          want = meter_results_q.pop_front();
          check_field("kind", 32'(want.kind), 32'(res.kind));
          check_field("tx_byte", 32'(want.tx_byte), 32'(res.tx_byte));
          check_field("last", 32'(want.last), 32'(res.last));
          check_field("voltage_tenths", 32'(want.voltage_tenths), 32'(res.voltage_tenths));
          check_field("current_hundredths", 32'(want.current_hundredths),
                      32'(res.current_hundredths));
          check_field("error_code", 32'(want.error_code), 32'(res.error_code));
          check_field("error_total", want.error_total, res.error_total);
        end
      end
      if (ev_valid && ev_ready) begin
        busy     = 1'b1;
        ev_taken = 1'b1;
        meter_step(live_meter, ev, fresh_n, fresh);
        for (int i = 0; i < fresh_n; i++) begin
          meter_results_q.push_back(fresh[i]);
        end
      end
      idle_cycles = busy ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_energy_meter_poll_master: done, errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence: reset, defaults, directed cases, then random runs under several settings
  // ---------------------------------------------------------------------------
  initial begin
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = REG_DEVICE_ADDRESS;
    cfg_data   = '0;
    ev_valid   = 1'b0;
    ev         = '0;
    res_ready  = 1'b0;
    items_made = 0;
    fail_count = 0;
    idle_cycles = 0;
    send_gap   = 0;
    recv_gap   = 0;
    send_calm  = 1'b0;
    recv_calm  = 1'b0;
    ev_taken   = 1'b0;
    res_taken  = 1'b0;
    live_meter = reset_state();
    plan_meter = live_meter;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset registers: request with the default address, two receive ticks
    push_item(OP_BYTE, 8'($urandom));
    repeat (3) push_item(OP_TICK, 8'($urandom));
    wait_quiet();

    write_reg(REG_DEVICE_ADDRESS, 32'h0000_0000);
    write_reg(REG_READ_TIMEOUT_MS, 32'd3);
    write_reg(REG_SETTLE_MS, 32'd0);
    write_reg(REG_UNUSED, $urandom);
    end_writes();

    // directed: still waiting for the voltage reply
    push_item(OP_BYTE, 8'h00);                              // leading zero skipped
    push_frame(RSP_VOLT, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0); // largest voltage
    push_item(OP_BYTE, 8'($urandom));                       // dropped in send phase
    push_item(OP_TICK, 8'($urandom));                       // current request, address zero
    push_frame(RSP_CURR, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0); // largest current
    push_item(OP_BYTE, 8'($urandom));                       // dropped while settling
    push_item(OP_TICK, 8'($urandom));                       // zero settle completes the cycle
    push_item(OP_TICK, 8'($urandom));                       // voltage request
    repeat (4) push_item(OP_TICK, 8'($urandom));            // silent meter, timeout on the last
    wait_quiet();

    for (int k = 0; k < SETTINGS_RUNS; k++) begin
      case (k)
        0: begin
          // settle never reached, timeout ends every settle phase
          write_reg(REG_DEVICE_ADDRESS, 32'hFFFF_FFFF);
          write_reg(REG_READ_TIMEOUT_MS, 32'd1);
          write_reg(REG_SETTLE_MS, 32'd65535);
        end
        1: begin
          // zero timeout fires on the first receive tick
          write_reg(REG_DEVICE_ADDRESS, $urandom);
          write_reg(REG_READ_TIMEOUT_MS, 32'd0);
          write_reg(REG_SETTLE_MS, 32'd0);
        end
        4: begin
          write_reg(REG_DEVICE_ADDRESS, $urandom);
          write_reg(REG_READ_TIMEOUT_MS, 32'd65535);
          write_reg(REG_SETTLE_MS, 32'($urandom_range(0, 4)));
        end
        default: begin
          write_reg(REG_DEVICE_ADDRESS, $urandom);
          write_reg(REG_READ_TIMEOUT_MS, 32'($urandom_range(2, 12)));
          write_reg(REG_SETTLE_MS, 32'($urandom_range(0, 8)));
        end
      endcase
      end_writes();
      run_random(PHASE_ITEMS);
      wait_quiet();
    end

    if (fail_count == 0) begin
      $display("tb_energy_meter_poll_master: done, clean");
    end else begin
      $display("tb_energy_meter_poll_master: done, errors");
    end
    $finish;
  end

endmodule
